[hw/rtl/bpfr_pkg.sv]
// shared types and constants for the buffer pool frame replacer
`default_nettype none
package bpfr_pkg;
	localparam int FRAMES_DEF  = 16;
	localparam int PIN_MAX_DEF = 255;
	localparam int PAGE_W      = 31;
	localparam int MAX_RES     = 16;

	localparam logic [1:0] CMD_PIN   = 2'd0;
	localparam logic [1:0] CMD_UNPIN = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOTRES  = 2'd1;
	localparam logic [1:0] ST_ALLPIN  = 2'd2;

	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_FRAMES = 1'b1;

	typedef struct packed {
		logic [3:0]        frame;
		logic              hit;
		logic              load_page;
		logic              evict_valid;
		logic [PAGE_W-1:0] old_page_id;
		logic              write_back;
		logic [1:0]        status;
		logic              last;
	} result_t;
endpackage
`default_nettype wire

[hw/rtl/bpfr_ram.sv]
// generic ram with one write port and one read port, registered read
`default_nettype none
module bpfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/buffer_pool_frame_replacer.sv]
// top level of the buffer pool frame replacer
// One command is handled at a time by a sequencer that walks the frames one per cycle
// through a single compare unit and the page id ram (a flush waits while a result beat
// is held). A pin makes one lookup pass over the frames in use, then a victim pass (lru:
// one pass plus a free scan; clock: free scan then up to two turns of the hand), then an
// update that reads the victim page and then commits, and in lru mode a recency pass over
// all FRAMES entries. An unpin makes a lookup pass and the update (lru adds the recency
// pass when the count reaches zero); a flush walks the frames once and emits one beat per
// dirty page. In clock mode the hand is first brought back into range after the pool was
// shrunk; the frame walk sets how long a pin takes.
// Input is not ready while a command is in progress or its last result beat waits.
`default_nettype none
module buffer_pool_frame_replacer #(
	parameter int FRAMES  = bpfr_pkg::FRAMES_DEF,
	parameter int PIN_MAX = bpfr_pkg::PIN_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [4:0]                  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  cmd,
	input  wire logic [bpfr_pkg::PAGE_W-1:0] page_id,
	input  wire logic                        mark_dirty,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [3:0]                       frame,
	output logic                             hit,
	output logic                             load_page,
	output logic                             evict_valid,
	output logic [bpfr_pkg::PAGE_W-1:0]      old_page_id,
	output logic                             write_back,
	output logic [1:0]                       status,
	output logic                             last
);
	import bpfr_pkg::*;

	localparam int FW = $clog2(FRAMES);
	localparam int CW = $clog2(FRAMES + 1);
	localparam int PW = $clog2(PIN_MAX + 1);
	localparam int SW = $clog2(2 * FRAMES + 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_LOOK   = 9'b000000010,
		S_LRU    = 9'b000000100,
		S_FREE   = 9'b000001000,
		S_SWEEP  = 9'b000010000,
		S_UPD    = 9'b000100000,
		S_TOUCH  = 9'b001000000,
		S_FLUSH  = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t state_q;
	logic mode_q;
	logic [4:0] act_q;
	logic [CW-1:0] n;

	logic [FRAMES-1:0] valid_q, dirty_q, ref_q, inlist_q;
	logic [PW-1:0] pin_q [FRAMES];
	logic [FW-1:0] rank_q [FRAMES];
	logic [FW-1:0] hand_q;

	logic [1:0] cmd_q;
	logic [PAGE_W-1:0] page_q;
	logic md_q;
	logic [FW-1:0] idx_q, found_q;
	logic found_v_q;
	logic [SW-1:0] cnt_q;
	logic [FW-1:0] rd_idx;
	logic [PAGE_W-1:0] rd_page;
	logic cmp_pending_q;
	logic [FW-1:0] cmp_idx_q;
	logic [4:0] nres_q;
	logic last_pending_q;
	logic lookup_hit_q;
	logic to_touch;

	logic ram_we;
	logic [FW-1:0] ram_wa;
	result_t res_q;

	always_comb begin
		if (act_q == 5'd0) begin
			n = CW'(1);
		end else if (32'(act_q) > 32'(FRAMES)) begin
			n = CW'(FRAMES);
		end else begin
			n = CW'(act_q);
		end
	end

	bpfr_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (page_q),
		.raddr (rd_idx),
		.rdata (rd_page)
	);

	assign in_ready    = (state_q == S_IDLE) && !out_valid;
	assign frame       = res_q.frame;
	assign hit         = res_q.hit;
	assign load_page   = res_q.load_page;
	assign evict_valid = res_q.evict_valid;
	assign old_page_id = res_q.old_page_id;
	assign write_back  = res_q.write_back;
	assign status      = res_q.status;
	assign last        = res_q.last;

	logic idx_end;
	assign idx_end = ({1'b0, idx_q} + 1'b1) >= (FW+1)'(n);

	// next hand position
	logic [FW-1:0] hand_m, hand_nx;
	always_comb begin
		hand_m  = ({1'b0, hand_q} >= (FW+1)'(n)) ? FW'(0) : hand_q;
		hand_nx = (({1'b0, hand_m} + 1'b1) >= (FW+1)'(n)) ? FW'(0) : FW'(hand_m + 1'b1);
	end

	assign to_touch = !mode_q && (cmd_q != CMD_UNPIN || pin_q[found_q] <= PW'(1));

	assign rd_idx = idx_q;
	assign ram_we = (state_q == S_UPD) && (cmd_q == CMD_PIN) && !lookup_hit_q
		&& cmp_pending_q;
	assign ram_wa = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= 1'b0;
			act_q     <= 5'd16;
			valid_q   <= '0;
			dirty_q   <= '0;
			ref_q     <= '0;
			inlist_q  <= '0;
			hand_q    <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < FRAMES; i++) begin
				pin_q[i]  <= '0;
				rank_q[i] <= '0;
			end
			cmd_q <= '0; page_q <= '0; md_q <= 1'b0; idx_q <= '0; found_q <= '0;
			found_v_q <= 1'b0; cnt_q <= '0; cmp_pending_q <= 1'b0; cmp_idx_q <= '0;
			nres_q <= '0; last_pending_q <= 1'b0; res_q <= '0;
		end else begin
			if (cfg_we && state_q == S_IDLE) begin
				if (cfg_index == CFG_MODE) begin
					mode_q <= cfg_data[0];
				end else begin
					act_q <= cfg_data;
				end
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= cmd; page_q <= page_id; md_q <= mark_dirty;
						idx_q <= '0; found_v_q <= 1'b0; cmp_pending_q <= 1'b0;
						nres_q <= '0;
						if (cmd == CMD_FLUSH) begin
							state_q <= S_FLUSH;
						end else if (cmd == CMD_PIN || cmd == CMD_UNPIN) begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					// ram read of idx_q lands next cycle; compare delayed entry
					if (cmp_pending_q && !found_v_q && valid_q[cmp_idx_q]
						&& rd_page == page_q) begin
						found_v_q <= 1'b1;
						found_q   <= cmp_idx_q;
					end
					cmp_idx_q     <= idx_q;
					if (!cmp_pending_q || !idx_end || cmp_idx_q != idx_q) begin
						cmp_pending_q <= 1'b1;
						if (!idx_end) idx_q <= idx_q + 1'b1;
					end
					if (cmp_pending_q && cmp_idx_q == idx_q && idx_end) begin
						cmp_pending_q <= 1'b0;
						idx_q <= '0;
						if (found_v_q || (valid_q[cmp_idx_q] && rd_page == page_q)) begin
							state_q <= S_UPD;
						end else if (cmd_q == CMD_UNPIN) begin
							res_q <= '{frame: 4'd0, hit: 1'b0, load_page: 1'b0,
								evict_valid: 1'b0, old_page_id: '0, write_back: 1'b0,
								status: ST_NOTRES, last: 1'b1};
							out_valid <= 1'b1;
							state_q <= S_IDLE;
						end else if (mode_q == 1'b0) begin
							state_q <= S_LRU;
						end else begin
							state_q <= S_FREE;
						end
					end
				end
				S_LRU: begin
					if (inlist_q[idx_q] && pin_q[idx_q] == '0 && (!found_v_q
						|| rank_q[idx_q] > rank_q[found_q])) begin
						found_v_q <= 1'b1;
						found_q   <= idx_q;
					end
					if (idx_end) begin
						idx_q <= '0;
						state_q <= S_FREE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FREE: begin
					if (found_v_q) begin
						state_q <= S_UPD; idx_q <= found_q;
					end else if (!valid_q[idx_q]) begin
						found_v_q <= 1'b1; found_q <= idx_q;
						state_q <= S_UPD;
					end else if (idx_end) begin
						cnt_q <= '0;
						if (mode_q) begin
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SWEEP: begin
					if ({1'b0, hand_q} >= (FW+1)'(n)) begin
						// bring the hand back into the pool
						hand_q <= hand_q - FW'(n);
					end else if (cnt_q >= SW'({n, 1'b0})) begin
						state_q <= S_OUT;
					end else begin
						cnt_q  <= cnt_q + 1'b1;
						hand_q <= hand_nx;
						if (pin_q[hand_m] == '0) begin
							if (ref_q[hand_m]) begin
								ref_q[hand_m] <= 1'b0;
							end else begin
								found_v_q <= 1'b1; found_q <= hand_m;
								idx_q <= hand_m;
								state_q <= S_UPD;
							end
						end
					end
				end
				S_OUT: begin
					res_q <= '{frame: 4'd0, hit: 1'b0, load_page: 1'b0,
						evict_valid: 1'b0, old_page_id: '0, write_back: 1'b0,
						status: ST_ALLPIN, last: 1'b1};
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				S_UPD: begin
					// read the victim page first, then commit
					if (!cmp_pending_q) begin
						cmp_pending_q <= 1'b1;
						idx_q <= found_q;
					end else begin
						cmp_pending_q <= 1'b0;
						idx_q <= '0;
						if (to_touch) begin
							state_q <= S_TOUCH;
						end else begin
							state_q <= S_IDLE;
							out_valid <= 1'b1;
						end
						if (cmd_q == CMD_UNPIN) begin
							if (md_q) dirty_q[found_q] <= 1'b1;
							if (pin_q[found_q] != '0) pin_q[found_q] <= pin_q[found_q] - 1'b1;
							res_q <= '{frame: 4'(found_q), hit: 1'b0, load_page: 1'b0,
								evict_valid: 1'b0, old_page_id: '0, write_back: 1'b0,
								status: ST_OK, last: 1'b1};
						end else if (lookup_hit_q) begin
							if (pin_q[found_q] < PW'(PIN_MAX)) begin
								pin_q[found_q] <= pin_q[found_q] + 1'b1;
							end
							if (mode_q) ref_q[found_q] <= 1'b1;
							res_q <= '{frame: 4'(found_q), hit: 1'b1, load_page: 1'b0,
								evict_valid: 1'b0, old_page_id: '0, write_back: 1'b0,
								status: ST_OK, last: 1'b1};
						end else begin
							valid_q[found_q] <= 1'b1;
							dirty_q[found_q] <= 1'b0;
							pin_q[found_q]   <= PW'(1);
							ref_q[found_q]   <= 1'b1;
							res_q <= '{frame: 4'(found_q), hit: 1'b0, load_page: 1'b1,
								evict_valid: valid_q[found_q],
								old_page_id: valid_q[found_q] ? rd_page : '0,
								write_back: valid_q[found_q] & dirty_q[found_q],
								status: ST_OK, last: 1'b1};
						end
					end
				end
				S_TOUCH: begin
					// one frame of the recency update per cycle
					if (idx_q != found_q && inlist_q[idx_q] && (!inlist_q[found_q]
						|| rank_q[idx_q] < rank_q[found_q])) begin
						rank_q[idx_q] <= rank_q[idx_q] + 1'b1;
					end
					if ({1'b0, idx_q} == (FW+1)'(FRAMES - 1)) begin
						inlist_q[found_q] <= 1'b1;
						rank_q[found_q]   <= '0;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FLUSH: begin
					// wait for result slot, read page, then emit
					if (!out_valid || out_ready) begin
						if (cmp_pending_q) begin
							cmp_pending_q <= 1'b0;
							res_q <= '{frame: 4'(cmp_idx_q), hit: 1'b0, load_page: 1'b0,
								evict_valid: 1'b0, old_page_id: rd_page, write_back: 1'b1,
								status: ST_OK, last: last_pending_q};
							out_valid <= 1'b1;
							dirty_q[cmp_idx_q] <= 1'b0;
							nres_q <= nres_q + 1'b1;
							if (last_pending_q) state_q <= S_IDLE;
						end else begin
							logic more;
							more = 1'b0;
							for (int j = 0; j < FRAMES; j++) begin
								if (j > int'(idx_q) && j < int'(n) && valid_q[j] && dirty_q[j])
									more = 1'b1;
							end
							if (valid_q[idx_q] && dirty_q[idx_q] && {1'b0, idx_q} < (FW+1)'(n)) begin
								cmp_pending_q  <= 1'b1;
								cmp_idx_q      <= idx_q;
								last_pending_q <= !more || (nres_q == 5'(MAX_RES - 1));
								idx_q <= idx_end ? idx_q : idx_q + 1'b1;
							end else if (idx_end || {1'b0, idx_q} >= (FW+1)'(n)) begin
								res_q <= '{frame: 4'd0, hit: 1'b0, load_page: 1'b0,
									evict_valid: 1'b0, old_page_id: '0, write_back: 1'b0,
									status: ST_OK, last: 1'b1};
								out_valid <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_hit_q <= 1'b0;
		end else if (state_q == S_IDLE) begin
			lookup_hit_q <= 1'b0;
		end else if (state_q == S_LOOK && cmp_pending_q && cmp_idx_q == idx_q && idx_end) begin
			lookup_hit_q <= found_v_q || (valid_q[cmp_idx_q] && rd_page == page_q);
		end
	end
endmodule
`default_nettype wire

[hw/rtl/bpfr_checker.sv]
// port level checks for the buffer pool frame replacer
`default_nettype none
module bpfr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] cmd,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       hit,
	input wire logic       load_page,
	input wire logic [1:0] status,
	input wire logic       last
);
	import bpfr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
	a_no_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_PIN || cmd == CMD_UNPIN || cmd == CMD_FLUSH)
		|=> !in_ready) else $error("ready while busy");
	a_hit_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && load_page)) else $error("hit and load together");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last) else $error("error beat not last");
endmodule

bind buffer_pool_frame_replacer bpfr_checker u_bpfr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
	.out_valid(out_valid), .out_ready(out_ready), .hit(hit),
	.load_page(load_page), .status(status), .last(last)
);
`default_nettype wire
